/* rtl/core/ptst_pkg.sv */
// Package: shared types and constants for the pattern-triggered send timer.
package ptst_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF  = 16;
  localparam int unsigned CFG_IDX_BITS    = 3;
  localparam int unsigned CFG_DATA_BITS   = 64;
  localparam int unsigned LOAD_BITS       = 32;

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_START = 2'd2,
    MODE_STOP  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PATTERN_BYTES  = 3'd0,
    CFG_PATTERN_LENGTH = 3'd1,
    CFG_DELAY_TICKS    = 3'd2,
    CFG_PERIOD_TICKS   = 3'd3,
    CFG_PERIODIC_MODE  = 3'd4,
    CFG_READ_TRIGGER   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] rx_byte;
    logic       link_up;
  } in_item_t;

  typedef struct packed {
    logic fire;
    logic is_active;
    logic start_refused;
    logic trigger_armed;
  } out_item_t;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic [15:0] delay_ticks;
    logic [15:0] period_ticks;
    logic        periodic_mode;
    logic        read_trigger_mode;
  } cfg_t;

endpackage

/* rtl/core/pattern_triggered_send_timer.sv */
// Top level: item registers around the pattern-triggered send timer engine.
// An accepted item lands in the input register, and its result is loaded into the
// output register when the input register advances.
// Throughput: 1 item per cycle; the input register advances whenever the output
// register is empty or being taken in the same cycle.
// Reset: asynchronous, active low; clears valid flags, timer state and all
// configuration registers. The configuration port is always ready.
module pattern_triggered_send_timer
  import ptst_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid_q;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q;
  logic      advance;
  logic      cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  ptst_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_write),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  ptst_engine #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/core/ptst_cfg.sv */
// Configuration register file for the pattern-triggered send timer.
module ptst_cfg
  import ptst_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_BYTES:  cfg_d.pattern_bytes     = cfg_data_i;
        CFG_PATTERN_LENGTH: cfg_d.pattern_length    = cfg_data_i[3:0];
        CFG_DELAY_TICKS:    cfg_d.delay_ticks       = cfg_data_i[15:0];
        CFG_PERIOD_TICKS:   cfg_d.period_ticks      = cfg_data_i[15:0];
        CFG_PERIODIC_MODE:  cfg_d.periodic_mode     = cfg_data_i[0];
        CFG_READ_TRIGGER:   cfg_d.read_trigger_mode = cfg_data_i[0];
        default:            cfg_d = cfg_q; // unused indexes: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/ptst_engine.sv */
// Timer state, pattern matcher and per-item next-state logic.
module ptst_engine
  import ptst_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  localparam int unsigned LEN_BITS = $clog2(MAX_PATTERN + 1);

  logic                  running_q, running_d;
  logic                  armed_q, armed_d;
  logic [LEN_BITS-1:0]   pos_q, pos_d;
  logic [COUNT_BITS-1:0] delay_q, delay_d;
  logic [COUNT_BITS-1:0] period_q, period_d;

  logic [LEN_BITS-1:0]   len_eff;
  logic [LEN_BITS-1:0]   pos_eff;
  logic [LEN_BITS-1:0]   pos_next;
  logic [7:0]            want_byte;
  logic [LOAD_BITS-1:0]  delay_wide;
  logic [LOAD_BITS-1:0]  period_wide;
  logic [COUNT_BITS-1:0] delay_load;
  logic [COUNT_BITS-1:0] period_load;
  logic [COUNT_BITS-1:0] delay_dec;
  logic [COUNT_BITS-1:0] period_dec;
  logic                  tick_counts;
  logic                  fire;
  logic                  refused;

  // Clamp the length, then restart a position left stale by a length change.
  assign len_eff = ({1'b0, cfg_i.pattern_length} > 5'(MAX_PATTERN)) ?
                   LEN_BITS'(MAX_PATTERN) : LEN_BITS'(cfg_i.pattern_length);
  assign pos_eff  = (pos_q >= len_eff) ? '0 : pos_q;
  assign pos_next = pos_eff + LEN_BITS'(1);

  always_comb begin
    want_byte = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (pos_eff == LEN_BITS'(k)) begin
        want_byte = cfg_i.pattern_bytes[8*k +: 8];
      end
    end
  end

  assign delay_wide  = LOAD_BITS'(cfg_i.delay_ticks);
  assign period_wide = LOAD_BITS'(cfg_i.period_ticks);
  assign delay_load  = delay_wide[COUNT_BITS-1:0];
  assign period_load = period_wide[COUNT_BITS-1:0];
  assign delay_dec   = (delay_q != '0) ? delay_q - COUNT_BITS'(1) : '0;
  assign period_dec  = period_q - COUNT_BITS'(1);
  assign tick_counts = running_q && !(cfg_i.read_trigger_mode && !armed_q);

  always_comb begin
    running_d = running_q;
    armed_d   = armed_q;
    pos_d     = pos_q;
    delay_d   = delay_q;
    period_d  = period_q;
    fire      = 1'b0;
    refused   = 1'b0;
    unique case (item_i.mode)
      MODE_BYTE: begin
        if (len_eff == '0) begin
          pos_d = '0;
        end else if (item_i.rx_byte == want_byte) begin
          if (pos_next == len_eff) begin
            armed_d = 1'b1;
            pos_d   = '0;
          end else begin
            pos_d = pos_next;
          end
        end else begin
          pos_d = '0;
        end
      end
      MODE_TICK: begin
        if (tick_counts) begin
          delay_d = delay_dec;
          if (delay_dec == '0) begin
            if (!cfg_i.periodic_mode) begin
              fire      = 1'b1;
              running_d = 1'b0;
              armed_d   = 1'b0;
              pos_d     = '0;
            end else if (period_q != '0) begin
              if (period_dec == '0) begin
                fire     = 1'b1;
                period_d = period_load;
              end else begin
                period_d = period_dec;
              end
            end
          end
        end
      end
      MODE_START: begin
        if (item_i.link_up) begin
          running_d = 1'b1;
          delay_d   = delay_load;
          period_d  = period_load;
          pos_d     = '0;
          armed_d   = 1'b0;
        end else begin
          refused = 1'b1;
        end
      end
      MODE_STOP: begin
        running_d = 1'b0;
        armed_d   = 1'b0;
        pos_d     = '0;
      end
      default: begin
        running_d = running_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      armed_q   <= 1'b0;
      pos_q     <= '0;
      delay_q   <= '0;
      period_q  <= '0;
    end else if (step_i) begin
      running_q <= running_d;
      armed_q   <= armed_d;
      pos_q     <= pos_d;
      delay_q   <= delay_d;
      period_q  <= period_d;
    end
  end

  assign result_o.fire          = fire;
  assign result_o.is_active     = running_d;
  assign result_o.start_refused = refused;
  assign result_o.trigger_armed = armed_d;

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < LEN_BITS'(MAX_PATTERN))
    else $error("match position beyond pattern capacity");

  a_fire_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (item_i.mode == MODE_TICK) && running_q)
    else $error("fire outside a running tick");

  a_refuse_no_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refused |-> (item_i.mode == MODE_START) && !item_i.link_up)
    else $error("start refused with link up");

  a_oneshot_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && fire && !cfg_i.periodic_mode |=> !running_q && !armed_q)
    else $error("one-shot fire left the timer running");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (item_i.mode == MODE_STOP) |=> !running_q && !armed_q && (pos_q == '0))
    else $error("stop did not clear state");
`endif

endmodule

/* bench/ptst_result_checker.sv */
// Checker: tracks register writes, predicts each result of the send timer and compares.
module ptst_result_checker
  import ptst_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  in_item_t                 in_item_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  out_item_t                out_item_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int unsigned              mismatches_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o,
  output int unsigned              fired_o
);

  // Register copies
  logic [63:0] cfg_pattern;
  logic [3:0]  cfg_len;
  logic [15:0] cfg_delay;
  logic [15:0] cfg_period;
  logic        cfg_periodic;
  logic        cfg_rtrig;

  // Timer state
  logic        running;
  logic [3:0]  match_pos;
  logic        armed;
  logic [15:0] delay_left;
  logic [15:0] period_left;

  out_item_t   expected_results[$];
  out_item_t   want;
  out_item_t   res;
  string       field_names[4] = '{"fire", "is_active", "start_refused", "trigger_armed"};

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", checked_o, msg);
    mismatches_o++;
  endtask

  task automatic halt_timer();
    running   = 1'b0;
    match_pos = '0;
    armed     = 1'b0;
  endtask

  task automatic predict_timer_item(input in_item_t it, output out_item_t r);
    logic [3:0] eff_len;
    logic [7:0] want_byte;
    r = '0;
    case (it.mode)
      MODE_BYTE: begin
        eff_len = (cfg_len > 4'(MAX_PATTERN_DEF)) ? 4'(MAX_PATTERN_DEF) : cfg_len;
        if (eff_len == 4'd0) begin
          match_pos = '0;
        end else begin
          // a position left over from a longer pattern restarts matching
          if (match_pos >= eff_len) match_pos = '0;
          want_byte = cfg_pattern[8*match_pos +: 8];
          if (it.rx_byte == want_byte) begin
            match_pos++;
            if (match_pos == eff_len) begin
              armed     = 1'b1;
              match_pos = '0;
            end
          end else begin
            match_pos = '0;
          end
        end
      end
      MODE_TICK: begin
        if (running && !(cfg_rtrig && !armed)) begin
          if (delay_left != 16'd0) delay_left--;
          if (delay_left == 16'd0) begin
            if (!cfg_periodic) begin
              r.fire = 1'b1;
              halt_timer();
            end else if (period_left != 16'd0) begin
              period_left--;
              if (period_left == 16'd0) begin
                r.fire      = 1'b1;
                period_left = cfg_period;
              end
            end
          end
        end
      end
      MODE_START: begin
        if (it.link_up) begin
          running     = 1'b1;
          delay_left  = cfg_delay;
          period_left = cfg_period;
          match_pos   = '0;
          armed       = 1'b0;
        end else begin
          r.start_refused = 1'b1;
        end
      end
      MODE_STOP: halt_timer();
      default: ;
    endcase
    r.is_active     = running;
    r.trigger_armed = armed;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pattern  = '0;
      cfg_len      = '0;
      cfg_delay    = '0;
      cfg_period   = '0;
      cfg_periodic = 1'b0;
      cfg_rtrig    = 1'b0;
      running      = 1'b0;
      match_pos    = '0;
      armed        = 1'b0;
      delay_left   = '0;
      period_left  = '0;
      expected_results.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      fired_o      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PATTERN_BYTES:  cfg_pattern  = cfg_data_i;
          CFG_PATTERN_LENGTH: cfg_len      = cfg_data_i[3:0];
          CFG_DELAY_TICKS:    cfg_delay    = cfg_data_i[15:0];
          CFG_PERIOD_TICKS:   cfg_period   = cfg_data_i[15:0];
          CFG_PERIODIC_MODE:  cfg_periodic = cfg_data_i[0];
          CFG_READ_TRIGGER:   cfg_rtrig    = cfg_data_i[0];
          default: ;
        endcase
      end
      // check the leaving item before queueing the arriving one
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %b with no item pending", out_item_i));
        end else begin
          want = expected_results.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (out_item_i[3-i] !== want[3-i])
              report_mismatch($sformatf("%s got %b expected %b", field_names[i],
                                        out_item_i[3-i], want[3-i]));
          end
          checked_o++;
          if (want.fire) fired_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_timer_item(in_item_i, res);
        expected_results.push_back(res);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* bench/tb_pattern_triggered_send_timer.sv */
// Testbench top: drives items and register writes into the send timer and reports the verdict.
module tb_pattern_triggered_send_timer;
  import ptst_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned ITEMS_PER_SET = 100;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  in_item_t                 in_item_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  out_item_t                out_item_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i  = '0;

  int unsigned mismatches, pending, checked, fired;
  int unsigned sent          = 0;
  int unsigned settings_used = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;

  // Pattern currently programmed, used to build matching byte runs
  logic [63:0] cur_pattern = '0;
  logic [3:0]  cur_len     = '0;

  always #5 clk_i = ~clk_i;

  pattern_triggered_send_timer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  ptst_result_checker timer_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .fired_o      (fired)
  );

  always @(posedge clk_i) begin
    out_ready_i <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results pending",
                 QUIET_LIMIT, pending);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_item(input mode_e m, input logic [7:0] b, input logic lk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{mode: m, rx_byte: b, link_up: lk};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_PATTERN_BYTES) cur_pattern = val;
    if (idx == CFG_PATTERN_LENGTH) cur_len = val[3:0];
  endtask

  task automatic apply_setting(input logic [63:0] pat, input logic [3:0] len,
                               input logic [15:0] dly, input logic [15:0] per,
                               input logic pm, input logic rt);
    wait_idle();
    write_reg(CFG_PATTERN_BYTES, pat);
    write_reg(CFG_PATTERN_LENGTH, 64'(len));
    write_reg(CFG_DELAY_TICKS, 64'(dly));
    write_reg(CFG_PERIOD_TICKS, 64'(per));
    write_reg(CFG_PERIODIC_MODE, 64'(pm));
    write_reg(CFG_READ_TRIGGER, 64'(rt));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly short counts so that firings happen often
  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 16'($urandom_range(3));
    if (r < 80) return 16'($urandom_range(4, 12));
    if (r < 92) return 16'd0;
    return 16'($urandom_range(65535));
  endfunction

  task automatic random_setting(input int unsigned kind);
    logic [63:0] pat;
    logic [3:0]  len;
    if (kind == 0) begin
      apply_setting(64'd0, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    end else if (kind == 1) begin
      apply_setting('1, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    end else begin
      pat = {$urandom, $urandom};
      // repeated leading bytes exercise restart after a partial match
      if ($urandom_range(2) == 0) pat[31:0] = {4{8'($urandom)}};
      len = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
      apply_setting(pat, len, pick_count(), pick_count(), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned stop_at, r, eff, i;
    stop_at = sent + n;
    while (sent < stop_at) begin
      r   = $urandom_range(99);
      eff = (cur_len > 4'(MAX_PATTERN_DEF)) ? MAX_PATTERN_DEF : cur_len;
      if (r < 10) begin
        push_item(MODE_START, 8'($urandom), $urandom_range(4) != 0);
      end else if (r < 14) begin
        push_item(MODE_STOP, 8'($urandom), 1'($urandom));
      end else if (r < 44) begin
        repeat ($urandom_range(1, 6)) push_item(MODE_TICK, 8'($urandom), 1'($urandom));
      end else if (r < 74) begin
        if (eff != 0 && $urandom_range(3) == 0)
          push_item(MODE_BYTE, cur_pattern[7:0], 1'($urandom));
        for (i = 0; i < eff; i++) begin
          push_item(MODE_BYTE, ($urandom_range(99) < 12) ? 8'($urandom) : cur_pattern[8*i +: 8],
                    1'($urandom));
        end
      end else if (r < 88) begin
        repeat ($urandom_range(1, 4)) push_item(MODE_BYTE, 8'($urandom), 1'($urandom));
      end else begin
        push_item(mode_e'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    logic [63:0] dir_pat;
    int unsigned regime, s;
    dir_pat       = 64'h0123_4567_89AB_CDEF;
    send_idle_pct = 7;
    recv_idle_pct = 45;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: stopped tick, idle stop, refused start, empty pattern, zero-delay one-shot
    push_item(MODE_TICK, 8'h00, 1'b1);
    push_item(MODE_STOP, 8'h00, 1'b1);
    push_item(MODE_START, 8'h00, 1'b0);
    push_item(MODE_BYTE, 8'h00, 1'b0);
    push_item(MODE_BYTE, 8'hFF, 1'b1);
    push_item(MODE_START, 8'hFF, 1'b1);
    push_item(MODE_TICK, 8'h00, 1'b0);
    push_item(MODE_TICK, 8'h00, 1'b1);

    // Over-long length, read trigger, periodic with zero period
    apply_setting(dir_pat, 4'd15, 16'd1, 16'd0, 1'b1, 1'b1);
    push_item(MODE_START, 8'h00, 1'b1);
    push_item(MODE_TICK, 8'h00, 1'b1);
    for (int i = 0; i < 8; i++) push_item(MODE_BYTE, dir_pat[8*i +: 8], 1'b0);
    push_item(MODE_TICK, 8'h00, 1'b1);
    for (int i = 0; i < 3; i++) push_item(MODE_BYTE, dir_pat[8*i +: 8], 1'b1);

    // Shorten the pattern while the match position sits past its end
    wait_idle();
    write_reg(CFG_PATTERN_LENGTH, 64'd2);
    cfg_valid_i <= 1'b0;
    push_item(MODE_BYTE, dir_pat[7:0], 1'b0);
    push_item(MODE_BYTE, dir_pat[15:8], 1'b0);
    push_item(MODE_STOP, 8'h00, 1'b0);

    for (regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 7 : (regime == 1) ? 45 : 0;
      recv_idle_pct = (regime == 0) ? 45 : (regime == 1) ? 7 : 0;
      for (s = 0; s < 6; s++) begin
        random_setting(s);
        run_traffic(ITEMS_PER_SET);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("Checked %0d results (%0d firings) from %0d items over %0d register settings,",
             checked, fired, sent, settings_used);
    $display("with sender and receiver stalls swapped between phases and a stall-free phase.");
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ptst_pkg.sv
rtl/core/ptst_cfg.sv
rtl/core/ptst_engine.sv
rtl/core/pattern_triggered_send_timer.sv
bench/ptst_result_checker.sv
bench/tb_pattern_triggered_send_timer.sv
